@@ rtl/jpt_pkg.sv @@
// Shared constants, codes and types of the joint probability table engine.
// No dependencies; the other files that use it refer to it by scoped names.
package jpt_pkg;

	localparam int MAX_VARIABLES   = 8;
	localparam int STATE_BITS      = 4;
	localparam int VAR_IDX_W       = 3;
	localparam int DEF_TABLE_DEPTH = 256;

	localparam int CMD_W       = 3;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int ROW_INDEX_W = 8;
	localparam int VSEL_W      = 3;
	localparam int SSEL_W      = 4;
	localparam int VALUE_OUT_W = 40;
	localparam int ROW_COUNT_W = 9;
	localparam int STATUS_W    = 3;
	localparam int VCOUNT_W    = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_VARIABLE_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATE_COUNTS   = 1'd1;

	localparam logic [VCOUNT_W-1:0]   VARIABLE_COUNT_RST = 4'd1;
	localparam logic [CFG_DATA_W-1:0] STATE_COUNTS_RST   = 32'h2222_2222;

	localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ_ROW  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MARGINAL  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NORMALIZE = 3'd5;
	localparam logic [CMD_W-1:0] CMD_FILL      = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED    = 3'd7;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd3;
	localparam logic [STATUS_W-1:0] STS_DIV_ZERO  = 3'd4;

	typedef logic [MAX_VARIABLES-1:0][STATE_BITS-1:0] counts_t;

	typedef struct packed {
		logic                busy;
		logic [VCOUNT_W-1:0] n_vars;
		counts_t             counts;
	} geom_t;

endpackage

@@ rtl/jpt_if.sv @@
// Request and result channel interfaces of the joint probability table engine.
// Depends on jpt_pkg for field widths.
interface jpt_req_if;
	logic                               valid;
	logic                               ready;
	logic [jpt_pkg::CMD_W-1:0]          command;
	logic [jpt_pkg::KEY_W-1:0]          key;
	logic [jpt_pkg::VALUE_W-1:0]        value_in;
	logic [jpt_pkg::ROW_INDEX_W-1:0]    row_index;
	logic [jpt_pkg::VSEL_W-1:0]         variable_select;
	logic [jpt_pkg::SSEL_W-1:0]         state_select;

	modport source (output valid, command, key, value_in, row_index, variable_select,
		state_select, input ready);
	modport sink (input valid, command, key, value_in, row_index, variable_select,
		state_select, output ready);
endinterface

interface jpt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [jpt_pkg::VALUE_OUT_W-1:0]    value_out;
	logic [jpt_pkg::KEY_W-1:0]          key_out;
	logic [jpt_pkg::ROW_COUNT_W-1:0]    row_count;
	logic [jpt_pkg::STATUS_W-1:0]       status;

	modport source (output valid, value_out, key_out, row_count, status, input ready);
	modport sink (input valid, value_out, key_out, row_count, status, output ready);
endinterface

@@ rtl/jpt_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module jpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/jpt_geom.sv @@
// Configuration registers and table geometry: digit weights and row count.
// Depends on jpt_pkg.
module jpt_geom #(
	parameter int TABLE_DEPTH = jpt_pkg::DEF_TABLE_DEPTH,
	localparam int WW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [jpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [jpt_pkg::CFG_DATA_W-1:0]      cfg_data,
	output jpt_pkg::geom_t                      geom,
	output logic [jpt_pkg::MAX_VARIABLES-1:0][WW-1:0] weights,
	output logic [WW-1:0]                       rows
);

	logic [jpt_pkg::VCOUNT_W-1:0]   var_count_q;
	logic [jpt_pkg::CFG_DATA_W-1:0] state_counts_q;
	logic                           busy_q;
	logic [jpt_pkg::VAR_IDX_W-1:0]  step_q;
	logic [WW-1:0]                  acc_q;
	logic                           ovf_q;
	logic [jpt_pkg::MAX_VARIABLES-1:0][WW-1:0] weights_q;
	logic [jpt_pkg::VCOUNT_W-1:0]   n_vars;
	jpt_pkg::counts_t               counts;
	logic [WW+jpt_pkg::STATE_BITS-1:0] prod;

	always_comb begin
		n_vars = var_count_q;
		if (var_count_q == '0) n_vars = jpt_pkg::VCOUNT_W'(1);
		if (var_count_q > jpt_pkg::VCOUNT_W'(jpt_pkg::MAX_VARIABLES))
			n_vars = jpt_pkg::VCOUNT_W'(jpt_pkg::MAX_VARIABLES);
		for (int i = 0; i < jpt_pkg::MAX_VARIABLES; i++) begin
			counts[i] = state_counts_q[i*jpt_pkg::STATE_BITS +: jpt_pkg::STATE_BITS];
			if (counts[i] < jpt_pkg::STATE_BITS'(2)) counts[i] = jpt_pkg::STATE_BITS'(2);
		end
	end

	assign prod = (WW+jpt_pkg::STATE_BITS)'(acc_q) * (WW+jpt_pkg::STATE_BITS)'(counts[step_q]);

	// walk from the fastest digit upwards, one multiply a cycle unless a configuration write restarts the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q    <= jpt_pkg::VARIABLE_COUNT_RST;
			state_counts_q <= jpt_pkg::STATE_COUNTS_RST;
			busy_q         <= 1'b1;
			step_q         <= jpt_pkg::VAR_IDX_W'(jpt_pkg::MAX_VARIABLES - 1);
			acc_q          <= WW'(1);
			ovf_q          <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == jpt_pkg::CFG_VARIABLE_COUNT) begin
				var_count_q <= cfg_data[jpt_pkg::VCOUNT_W-1:0];
			end else if (cfg_index == jpt_pkg::CFG_STATE_COUNTS) begin
				state_counts_q <= cfg_data;
			end
			busy_q <= 1'b1;
			step_q <= jpt_pkg::VAR_IDX_W'(jpt_pkg::MAX_VARIABLES - 1);
			acc_q  <= WW'(1);
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			if (jpt_pkg::VCOUNT_W'(step_q) < n_vars) begin
				if (prod > (WW+jpt_pkg::STATE_BITS)'(TABLE_DEPTH)) ovf_q <= 1'b1;
				else acc_q <= WW'(prod);
			end
			if (step_q == '0) busy_q <= 1'b0;
			else step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we) begin
			if (jpt_pkg::VCOUNT_W'(step_q) < n_vars) weights_q[step_q] <= acc_q;
			else weights_q[step_q] <= '0;
		end
	end

	assign geom.busy   = busy_q;
	assign geom.n_vars = n_vars;
	assign geom.counts = counts;
	assign weights     = weights_q;
	assign rows        = ovf_q ? '0 : acc_q;

endmodule

@@ rtl/jpt_div.sv @@
// Restoring divider, one quotient bit a cycle.
// No dependencies.
module jpt_div #(
	parameter int DIVIDEND_W = 48,
	parameter int DIVISOR_W  = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/joint_probability_table_engine.sv @@
// Joint probability table engine: one Q16.16 entry per key in a single-port RAM.
// Get, set and add touch one row; read row also decodes the row index into key digits;
// marginal sweeps all rows; normalize divides every row, summing the table first when value_in is zero.
// One request at a time; the next is taken once the sequencer is back in idle after its result
// moves to the output register, and a finished result waits there while the next request runs.
// After reset the RAM is cleared to zero and no request is taken meanwhile;
// a configuration write holds requests off until the geometry is recomputed.
module joint_probability_table_engine #(
	parameter int TABLE_DEPTH = jpt_pkg::DEF_TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jpt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [jpt_pkg::CFG_DATA_W-1:0]  cfg_data,
	jpt_req_if.sink                         request,
	jpt_rsp_if.source                       result
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int WW   = $clog2(TABLE_DEPTH + 1);
	localparam int SB   = jpt_pkg::STATE_BITS;
	localparam int MV   = jpt_pkg::MAX_VARIABLES;
	localparam int RSW  = WW + SB + 3;
	localparam int DVW  = 32 + AW;
	localparam int SUMW = (DVW > 40) ? DVW : 40;
	localparam int QW   = 48;
	localparam int CW   = (WW > 8) ? WW + 1 : 9;
	localparam logic [SUMW:0] LIM40 = {{(SUMW-39){1'b0}}, {40{1'b1}}};

	// sequencer states
	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DECODE = 4'd2;
	localparam logic [3:0] ST_RMW    = 4'd3;
	localparam logic [3:0] ST_RROW   = 4'd4;
	localparam logic [3:0] ST_SWEEP  = 4'd5;
	localparam logic [3:0] ST_NRD    = 4'd6;
	localparam logic [3:0] ST_NSTART = 4'd7;
	localparam logic [3:0] ST_NWAIT  = 4'd8;
	localparam logic [3:0] ST_FILL   = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	jpt_pkg::geom_t          geom;
	logic [MV-1:0][WW-1:0]   weights;
	logic [WW-1:0]           rows;

	logic [3:0]              state_q;
	logic [jpt_pkg::CMD_W-1:0]       cmd_q;
	logic [jpt_pkg::KEY_W-1:0]       key_q;
	logic [jpt_pkg::VALUE_W-1:0]     val_q;
	logic [jpt_pkg::ROW_INDEX_W-1:0] ridx_q;
	logic [jpt_pkg::VSEL_W-1:0]      vsel_q;
	logic [jpt_pkg::SSEL_W-1:0]      ssel_q;

	logic [WW-1:0]           cnt_q;
	logic [AW-1:0]           addr_q;
	logic [WW-1:0]           rem_q;
	logic [jpt_pkg::VAR_IDX_W-1:0] vi_q;
	jpt_pkg::counts_t        odo_q;
	logic                    all_q;
	logic                    pend_s1;
	logic                    match_s1;
	logic [SUMW-1:0]         sum_q;
	logic [DVW-1:0]          div_q;

	logic [jpt_pkg::VALUE_OUT_W-1:0] res_value_q;
	logic [jpt_pkg::KEY_W-1:0]       res_key_q;
	logic [jpt_pkg::STATUS_W-1:0]    res_status_q;

	logic                            out_valid_q;
	logic [jpt_pkg::VALUE_OUT_W-1:0] out_value_q;
	logic [jpt_pkg::KEY_W-1:0]       out_key_q;
	logic [jpt_pkg::ROW_COUNT_W-1:0] out_rows_q;
	logic [jpt_pkg::STATUS_W-1:0]    out_status_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_addr;
	logic [31:0]             ram_wdata;
	logic [31:0]             ram_rdata;

	logic                    div_busy;
	logic [QW-1:0]           div_quo;
	logic [31:0]             q_sat;

	logic                    key_ok;
	logic [RSW-1:0]          row_sum;
	logic                    row_hit;
	logic                    ridx_bad;
	jpt_pkg::counts_t        odo_nx;
	logic                    carry;
	logic [WW-1:0]           w_sel;
	logic [WW-1:0]           rem_t;
	logic [SB-1:0]           dig;
	logic [WW+SB-1:0]        w_sh;
	logic [32:0]             add_sum;
	logic [31:0]             new_val;
	logic [SUMW:0]           sum_add;
	logic [SUMW-1:0]         sum_nx;
	logic [SUMW:0]           div_ext;
	logic [jpt_pkg::VALUE_OUT_W-1:0] div_sat;
	logic                    issue;
	logic                    accept;
	logic                    out_load;

	jpt_geom #(.TABLE_DEPTH(TABLE_DEPTH)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.weights   (weights),
		.rows      (rows)
	);

	jpt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	jpt_div #(.DIVIDEND_W(QW), .DIVISOR_W(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_NSTART),
		.dividend ({ram_rdata, 16'h0000}),
		.divisor  (div_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Take a request only when idle and the geometry has settled.
	assign request.ready = (state_q == ST_IDLE) && !geom.busy;
	assign accept        = request.valid && request.ready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// Key to row: weighted sum of the digits, rejecting any digit past its count.
	always_comb begin
		key_ok  = 1'b1;
		row_sum = '0;
		for (int i = 0; i < MV; i++) begin
			if (i < int'(geom.n_vars)) begin
				if (key_q[i*SB +: SB] >= geom.counts[i]) key_ok = 1'b0;
				row_sum = row_sum + RSW'(key_q[i*SB +: SB]) * RSW'(weights[i]);
			end
		end
		row_hit  = key_ok && (row_sum < RSW'(TABLE_DEPTH));
		ridx_bad = (CW'(ridx_q) >= CW'(rows)) || (CW'(ridx_q) >= CW'(TABLE_DEPTH));
	end

	// Odometer over the keys in row order, last variable fastest.
	always_comb begin
		carry  = 1'b1;
		odo_nx = odo_q;
		for (int i = MV - 1; i >= 0; i--) begin
			if (i < int'(geom.n_vars) && carry) begin
				if (odo_q[i] == geom.counts[i] - 1'b1) begin
					odo_nx[i] = '0;
				end else begin
					odo_nx[i] = odo_q[i] + 1'b1;
					carry     = 1'b0;
				end
			end
		end
	end

	// Row to key: one digit a cycle by shift-and-subtract of the digit weight.
	always_comb begin
		w_sel = weights[vi_q];
		rem_t = rem_q;
		dig   = '0;
		w_sh  = '0;
		if (jpt_pkg::VCOUNT_W'(vi_q) < geom.n_vars) begin
			for (int k = SB - 1; k >= 0; k--) begin
				w_sh = (WW+SB)'(w_sel) << k;
				if ((WW+SB)'(rem_t) >= w_sh) begin
					rem_t  = rem_t - WW'(w_sh);
					dig[k] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		add_sum = {1'b0, ram_rdata} + {1'b0, val_q};
		case (cmd_q)
			jpt_pkg::CMD_SET: new_val = val_q;
			jpt_pkg::CMD_ADD: new_val = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
			default:          new_val = ram_rdata;
		endcase
		sum_add = (SUMW+1)'(sum_q) + (SUMW+1)'(ram_rdata);
		if (!all_q && sum_add > LIM40) sum_nx = SUMW'(LIM40);
		else sum_nx = SUMW'(sum_add);
		div_ext = (SUMW+1)'(div_q);
		div_sat = (div_ext > LIM40) ? '1 : div_ext[jpt_pkg::VALUE_OUT_W-1:0];
		q_sat   = (|div_quo[QW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
		issue   = cnt_q < rows;
	end

	// RAM port steering per state.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = AW'(cnt_q);
		ram_wdata = val_q;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_DECODE: begin
				ram_addr = (cmd_q == jpt_pkg::CMD_READ_ROW) ? AW'(ridx_q) : AW'(row_sum);
			end
			ST_RMW: begin
				ram_addr  = addr_q;
				ram_we    = cmd_q != jpt_pkg::CMD_GET;
				ram_wdata = new_val;
			end
			ST_RROW: ram_addr = addr_q;
			ST_FILL: ram_we = issue;
			ST_NWAIT: begin
				ram_we    = !div_busy;
				ram_wdata = q_sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (cnt_q == WW'(TABLE_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: if (accept) state_q <= ST_DECODE;
				ST_DECODE: begin
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					if (cmd_q == jpt_pkg::CMD_UNUSED || rows == '0) begin
						state_q <= ST_DONE;
					end else begin
						case (cmd_q)
							jpt_pkg::CMD_GET, jpt_pkg::CMD_SET, jpt_pkg::CMD_ADD:
								state_q <= row_hit ? ST_RMW : ST_DONE;
							jpt_pkg::CMD_READ_ROW:
								state_q <= ridx_bad ? ST_DONE : ST_RROW;
							jpt_pkg::CMD_MARGINAL:
								state_q <= (jpt_pkg::VCOUNT_W'(vsel_q) >= geom.n_vars) ?
									ST_DONE : ST_SWEEP;
							jpt_pkg::CMD_NORMALIZE:
								state_q <= (val_q != '0) ? ST_NRD : ST_SWEEP;
							default: state_q <= ST_FILL;
						endcase
					end
				end
				ST_RMW: state_q <= ST_DONE;
				ST_RROW: if (vi_q == jpt_pkg::VAR_IDX_W'(MV - 1)) state_q <= ST_DONE;
				ST_SWEEP: begin
					pend_s1 <= issue;
					if (issue) cnt_q <= cnt_q + 1'b1;
					if (!issue && !pend_s1) begin
						cnt_q <= '0;
						if (all_q && sum_q != '0) state_q <= ST_NRD;
						else state_q <= ST_DONE;
					end
				end
				ST_NRD: state_q <= ST_NSTART;
				ST_NSTART: state_q <= ST_NWAIT;
				ST_NWAIT: begin
					if (!div_busy) begin
						if (WW'(cnt_q + 1'b1) == rows) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_NRD;
						end
					end
				end
				ST_FILL: begin
					if (issue) cnt_q <= cnt_q + 1'b1;
					else state_q <= ST_DONE;
				end
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; control above owns the sequencing.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= request.command;
			key_q  <= request.key;
			val_q  <= request.value_in;
			ridx_q <= request.row_index;
			vsel_q <= request.variable_select;
			ssel_q <= request.state_select;
		end
		case (state_q)
			ST_DECODE: begin
				res_value_q  <= '0;
				res_key_q    <= '0;
				res_status_q <= jpt_pkg::STS_OK;
				odo_q        <= '0;
				sum_q        <= '0;
				vi_q         <= '0;
				all_q        <= cmd_q == jpt_pkg::CMD_NORMALIZE;
				div_q        <= DVW'(val_q);
				rem_q        <= WW'(ridx_q);
				addr_q       <= (cmd_q == jpt_pkg::CMD_READ_ROW) ? AW'(ridx_q) : AW'(row_sum);
				if (cmd_q == jpt_pkg::CMD_UNUSED) begin
					res_status_q <= jpt_pkg::STS_RANGE;
				end else if (rows == '0) begin
					res_status_q <= jpt_pkg::STS_TOO_LARGE;
				end else begin
					case (cmd_q)
						jpt_pkg::CMD_GET, jpt_pkg::CMD_SET, jpt_pkg::CMD_ADD:
							if (!row_hit) res_status_q <= jpt_pkg::STS_NOT_FOUND;
						jpt_pkg::CMD_READ_ROW:
							if (ridx_bad) res_status_q <= jpt_pkg::STS_RANGE;
						jpt_pkg::CMD_MARGINAL:
							if (jpt_pkg::VCOUNT_W'(vsel_q) >= geom.n_vars)
								res_status_q <= jpt_pkg::STS_RANGE;
						jpt_pkg::CMD_FILL: res_value_q <= jpt_pkg::VALUE_OUT_W'(val_q);
						default: ;
					endcase
				end
			end
			ST_RMW: res_value_q <= jpt_pkg::VALUE_OUT_W'(new_val);
			ST_RROW: begin
				res_value_q <= jpt_pkg::VALUE_OUT_W'(ram_rdata);
				res_key_q[vi_q*SB +: SB] <= dig;
				rem_q <= rem_t;
				vi_q  <= vi_q + 1'b1;
			end
			ST_SWEEP: begin
				if (issue) begin
					odo_q    <= odo_nx;
					match_s1 <= all_q || (odo_q[vsel_q] == ssel_q);
				end
				if (pend_s1 && match_s1) sum_q <= sum_nx;
				if (!issue && !pend_s1) begin
					if (all_q) begin
						div_q <= DVW'(sum_q);
						if (sum_q == '0) res_status_q <= jpt_pkg::STS_DIV_ZERO;
					end else begin
						res_value_q <= sum_q[jpt_pkg::VALUE_OUT_W-1:0];
					end
				end
			end
			ST_NWAIT: res_value_q <= div_sat;
			default: ;
		endcase
	end

	// Output register: hold a result until taken, load the next when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_key_q    <= res_key_q;
			out_rows_q   <= jpt_pkg::ROW_COUNT_W'(rows);
			out_status_q <= res_status_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.value_out = out_value_q;
	assign result.key_out   = out_key_q;
	assign result.row_count = out_rows_q;
	assign result.status    = out_status_q;

endmodule
